/* hdl/rau_pkg.sv */
`default_nettype none
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int RES_BITS  = (WORD_BITS > 32) ? 32 : WORD_BITS;
    localparam logic [63:0] RES_LIM = 64'((64'd1 << (RES_BITS - 1)) - 64'd1);

    localparam logic [2:0] K_ADD  = 3'd0;
    localparam logic [2:0] K_SUB  = 3'd1;
    localparam logic [2:0] K_MUL  = 3'd2;
    localparam logic [2:0] K_DIV  = 3'd3;
    localparam logic [2:0] K_CMP  = 3'd4;
    localparam logic [2:0] K_NORM = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_GCD_START,
        OP_DIVN_START,
        OP_DIVD_START,
        OP_SAVE_A,
        OP_SAVE_B,
        OP_LCM_SETUP,
        OP_M_ANBN,
        OP_M_ADBD,
        OP_M_ANBD,
        OP_M_ADBN,
        OP_M_L,
        OP_M_TA,
        OP_M_TB,
        OP_COMBINE,
        OP_RES_FRAC,
        OP_RES_CMP,
        OP_RES_ERR
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       bad_kind;
        logic       zden;
        logic       bn_zero;
        logic       gcd_done;
        logic       div_done;
    } dp_stat_t;

endpackage
`default_nettype wire

/* hdl/rau_gcd.sv */
`default_nettype none
module rau_gcd import rau_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         start,
    input  wire  [63:0] x_in,
    input  wire  [63:0] y_in,
    output logic        done,
    output logic [63:0] g_out
);
    // Binary gcd: one halving or one subtraction per cycle.
    logic [63:0] x_reg, x_next, y_reg, y_next, g_reg, g_next;
    logic [5:0]  k_reg, k_next;
    logic        busy_reg, busy_next, done_reg, done_next;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = x_in;
            y_next    = y_in;
            k_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (x_reg == 64'd0 || y_reg == 64'd0) begin
                g_next    = (x_reg | y_reg) << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!x_reg[0] && !y_reg[0]) begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 6'd1;
            end else if (!x_reg[0]) begin
                x_next = x_reg >> 1;
            end else if (!y_reg[0]) begin
                y_next = y_reg >> 1;
            end else if (x_reg >= y_reg) begin
                x_next = x_reg - y_reg;
            end else begin
                y_next = y_reg - x_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        k_reg <= k_next;
        g_reg <= g_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done  = done_reg;
    assign g_out = g_reg;
endmodule
`default_nettype wire

/* hdl/rau_div.sv */
`default_nettype none
module rau_div import rau_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         start,
    input  wire  [63:0] dividend,
    input  wire  [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    // Restoring division, one quotient bit per cycle.
    logic [64:0] r_reg, r_next, r_sh;
    logic [63:0] q_reg, q_next, d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;

    always_comb begin
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        r_sh      = {r_reg[63:0], q_reg[63]};
        if (start) begin
            r_next    = '0;
            q_next    = dividend;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (r_sh >= {1'b0, d_reg}) begin
                r_next = r_sh - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = r_sh;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        r_reg   <= r_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

/* hdl/rau_datapath.sv */
`default_nettype none
module rau_datapath import rau_pkg::*; (
    input  wire          aclk,
    input  wire          aresetn,
    input  dp_cmd_t      cmd,
    input  wire  [127:0] in_data,
    input  wire  [2:0]   in_kind,
    output dp_stat_t     stat,
    output logic [31:0]  res_num,
    output logic [30:0]  res_den,
    output logic         res_gt,
    output logic         res_eq,
    output logic         res_lt,
    output logic [1:0]   res_status
);
    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    logic [2:0]  kind_reg;
    logic        bad_reg, zden_reg;
    logic [31:0] bnum_raw_reg, bden_raw_reg;
    logic [31:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic        aneg_reg, bneg_reg;
    logic [63:0] rn_reg, rd_reg, gr_reg, tl_reg, ta_reg, tb_reg;
    logic        rneg_reg;
    logic        dst_reg;
    logic [31:0] num_o_reg;
    logic [30:0] den_o_reg;
    logic        gt_o_reg, eq_o_reg, lt_o_reg;
    logic [1:0]  st_o_reg;

    logic        gcd_done, div_done;
    logic [63:0] gcd_g, div_q;
    logic        div_start;
    logic [63:0] div_dvd;

    assign div_start = (cmd.op == OP_DIVN_START) || (cmd.op == OP_DIVD_START);
    assign div_dvd   = (cmd.op == OP_DIVD_START) ? rd_reg : rn_reg;

    rau_gcd u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == OP_GCD_START),
        .x_in    (rn_reg),
        .y_in    (rd_reg),
        .done    (gcd_done),
        .g_out   (gcd_g)
    );

    rau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (gr_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Shared 32x32 multiplier; the destination register follows it.
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    always_comb begin
        case (cmd.op)
            OP_M_ANBN: begin mul_a = an_reg;        mul_b = bn_reg;        end
            OP_M_ADBD: begin mul_a = ad_reg;        mul_b = bd_reg;        end
            OP_M_ANBD: begin mul_a = an_reg;        mul_b = bd_reg;        end
            OP_M_ADBN: begin mul_a = ad_reg;        mul_b = bn_reg;        end
            OP_M_L:    begin mul_a = rn_reg[31:0];  mul_b = bd_reg;        end
            OP_M_TA:   begin mul_a = an_reg;        mul_b = rd_reg[31:0];  end
            OP_M_TB:   begin mul_a = bn_reg;        mul_b = rn_reg[31:0];  end
            default:   begin mul_a = '0;            mul_b = '0;            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    logic sb;
    assign sb = (kind_reg == K_SUB) ? !bneg_reg : bneg_reg;

    logic eff_neg, ovf;
    assign eff_neg = rneg_reg && (rn_reg != 64'd0);
    assign ovf = (rd_reg > RES_LIM) || (rn_reg > (eff_neg ? RES_LIM + 64'd1 : RES_LIM));

    logic signed [64:0] cx, cy;
    assign cx = aneg_reg ? -$signed({1'b0, rn_reg}) : $signed({1'b0, rn_reg});
    assign cy = bneg_reg ? -$signed({1'b0, rd_reg}) : $signed({1'b0, rd_reg});

    always_ff @(posedge aclk) begin
        if (gcd_done) gr_reg <= gcd_g;
        if (div_done) begin
            if (dst_reg) rd_reg <= div_q;
            else         rn_reg <= div_q;
        end
        unique case (cmd.op)
            OP_LOAD: begin
                kind_reg     <= in_kind;
                bad_reg      <= in_kind > K_NORM;
                zden_reg     <= (in_data[63:32] == 32'd0) ||
                                (in_kind != K_NORM && in_data[127:96] == 32'd0);
                bnum_raw_reg <= in_data[95:64];
                bden_raw_reg <= in_data[127:96];
                rn_reg       <= {32'd0, abs32(in_data[31:0])};
                rd_reg       <= {32'd0, abs32(in_data[63:32])};
                rneg_reg     <= in_data[31] ^ in_data[63];
            end
            OP_DIVN_START: dst_reg <= 1'b0;
            OP_DIVD_START: dst_reg <= 1'b1;
            OP_SAVE_A: begin
                an_reg   <= rn_reg[31:0];
                ad_reg   <= rd_reg[31:0];
                aneg_reg <= eff_neg;
                rn_reg   <= {32'd0, abs32(bnum_raw_reg)};
                rd_reg   <= {32'd0, abs32(bden_raw_reg)};
                rneg_reg <= bnum_raw_reg[31] ^ bden_raw_reg[31];
            end
            OP_SAVE_B: begin
                bn_reg   <= rn_reg[31:0];
                bd_reg   <= rd_reg[31:0];
                bneg_reg <= eff_neg;
            end
            OP_LCM_SETUP: begin
                rn_reg <= {32'd0, ad_reg};
                rd_reg <= {32'd0, bd_reg};
            end
            OP_M_ANBN, OP_M_ANBD: rn_reg <= prod;
            OP_M_ADBD, OP_M_ADBN: begin
                rd_reg   <= prod;
                rneg_reg <= aneg_reg ^ bneg_reg;
            end
            OP_M_L:  tl_reg <= prod;
            OP_M_TA: ta_reg <= prod;
            OP_M_TB: tb_reg <= prod;
            OP_COMBINE: begin
                rd_reg <= tl_reg;
                if (aneg_reg == sb) begin
                    rn_reg   <= ta_reg + tb_reg;
                    rneg_reg <= aneg_reg;
                end else if (ta_reg >= tb_reg) begin
                    rn_reg   <= ta_reg - tb_reg;
                    rneg_reg <= aneg_reg;
                end else begin
                    rn_reg   <= tb_reg - ta_reg;
                    rneg_reg <= sb;
                end
            end
            OP_RES_FRAC: begin
                gt_o_reg <= 1'b0;
                eq_o_reg <= 1'b0;
                lt_o_reg <= 1'b0;
                if (ovf) begin
                    num_o_reg <= '0;
                    den_o_reg <= 31'd1;
                    st_o_reg  <= ST_OVF;
                end else begin
                    num_o_reg <= eff_neg ? (~rn_reg[31:0] + 32'd1) : rn_reg[31:0];
                    den_o_reg <= rd_reg[30:0];
                    st_o_reg  <= ST_OK;
                end
            end
            OP_RES_CMP: begin
                num_o_reg <= '0;
                den_o_reg <= 31'd1;
                gt_o_reg  <= cx > cy;
                eq_o_reg  <= cx == cy;
                lt_o_reg  <= cx < cy;
                st_o_reg  <= ST_OK;
            end
            OP_RES_ERR: begin
                num_o_reg <= '0;
                den_o_reg <= 31'd1;
                gt_o_reg  <= 1'b0;
                eq_o_reg  <= 1'b0;
                lt_o_reg  <= 1'b0;
                st_o_reg  <= cmd.status;
            end
            default: ;
        endcase
    end

    assign stat.kind     = kind_reg;
    assign stat.bad_kind = bad_reg;
    assign stat.zden     = zden_reg;
    assign stat.bn_zero  = (bn_reg == 32'd0);
    assign stat.gcd_done = gcd_done;
    assign stat.div_done = div_done;

    assign res_num    = num_o_reg;
    assign res_den    = den_o_reg;
    assign res_gt     = gt_o_reg;
    assign res_eq     = eq_o_reg;
    assign res_lt     = lt_o_reg;
    assign res_status = st_o_reg;
endmodule
`default_nettype wire

/* hdl/rau_ctrl.sv */
`default_nettype none
module rau_ctrl import rau_pkg::*; (
    input  wire      aclk,
    input  wire      aresetn,
    input  wire      s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  wire      m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_GCD_GO, S_GCD_WAIT, S_DIVN_GO, S_DIVN_WAIT,
        S_DIVD_GO, S_DIVD_WAIT, S_AFTER, S_OPSEL, S_MUL2, S_XD2,
        S_ML, S_MTA, S_MTB, S_COMB, S_EMIT
    } state_t;

    typedef enum logic [1:0] {PH_A, PH_B, PH_LCM, PH_RES} phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    dp_op_t     eop_reg, eop_next;
    logic [1:0] est_reg, est_next;
    logic       mv_reg, mv_next;
    logic       slot_free;

    assign slot_free = !mv_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        eop_next   = eop_reg;
        est_next   = est_reg;
        cmd.op     = OP_NONE;
        cmd.status = est_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) begin
                cmd.op     = OP_LOAD;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (stat.bad_kind) begin
                    eop_next = OP_RES_ERR; est_next = ST_OK;   state_next = S_EMIT;
                end else if (stat.zden) begin
                    eop_next = OP_RES_ERR; est_next = ST_ZDEN; state_next = S_EMIT;
                end else begin
                    phase_next = PH_A;
                    state_next = S_GCD_GO;
                end
            end
            S_GCD_GO:    begin cmd.op = OP_GCD_START; state_next = S_GCD_WAIT; end
            S_GCD_WAIT:  if (stat.gcd_done) state_next = S_DIVN_GO;
            S_DIVN_GO:   begin cmd.op = OP_DIVN_START; state_next = S_DIVN_WAIT; end
            S_DIVN_WAIT: if (stat.div_done) state_next = S_DIVD_GO;
            S_DIVD_GO:   begin cmd.op = OP_DIVD_START; state_next = S_DIVD_WAIT; end
            S_DIVD_WAIT: if (stat.div_done) state_next = S_AFTER;
            S_AFTER: begin
                unique case (phase_reg)
                    PH_A: begin
                        if (stat.kind == K_NORM) begin
                            eop_next = OP_RES_FRAC; state_next = S_EMIT;
                        end else begin
                            cmd.op     = OP_SAVE_A;
                            phase_next = PH_B;
                            state_next = S_GCD_GO;
                        end
                    end
                    PH_B: begin
                        cmd.op     = OP_SAVE_B;
                        state_next = S_OPSEL;
                    end
                    PH_LCM: state_next = S_ML;
                    default: begin
                        eop_next = OP_RES_FRAC; state_next = S_EMIT;
                    end
                endcase
            end
            S_OPSEL: begin
                unique case (stat.kind)
                    K_ADD, K_SUB: begin
                        cmd.op     = OP_LCM_SETUP;
                        phase_next = PH_LCM;
                        state_next = S_GCD_GO;
                    end
                    K_MUL: begin
                        cmd.op     = OP_M_ANBN;
                        state_next = S_MUL2;
                    end
                    K_DIV: begin
                        if (stat.bn_zero) begin
                            eop_next = OP_RES_ERR; est_next = ST_DIVZ; state_next = S_EMIT;
                        end else begin
                            cmd.op     = OP_M_ANBD;
                            state_next = S_XD2;
                        end
                    end
                    default: begin
                        cmd.op     = OP_M_ANBD;
                        state_next = S_XD2;
                    end
                endcase
            end
            S_MUL2: begin
                cmd.op     = OP_M_ADBD;
                phase_next = PH_RES;
                state_next = S_GCD_GO;
            end
            S_XD2: begin
                cmd.op = OP_M_ADBN;
                if (stat.kind == K_CMP) begin
                    eop_next   = OP_RES_CMP;
                    state_next = S_EMIT;
                end else begin
                    phase_next = PH_RES;
                    state_next = S_GCD_GO;
                end
            end
            S_ML:  begin cmd.op = OP_M_L;  state_next = S_MTA; end
            S_MTA: begin cmd.op = OP_M_TA; state_next = S_MTB; end
            S_MTB: begin cmd.op = OP_M_TB; state_next = S_COMB; end
            S_COMB: begin
                cmd.op     = OP_COMBINE;
                phase_next = PH_RES;
                state_next = S_GCD_GO;
            end
            S_EMIT: if (slot_free) begin
                cmd.op     = eop_reg;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        if (state_reg == S_EMIT && slot_free) mv_next = 1'b1;
        else if (m_tready)                    mv_next = 1'b0;
        else                                  mv_next = mv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_A;
            eop_reg   <= OP_RES_ERR;
            est_reg   <= ST_OK;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            eop_reg   <= eop_next;
            est_reg   <= est_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
endmodule
`default_nettype wire

/* hdl/rational_arith_unit.sv */
// Rational arithmetic unit: exact add, subtract, multiply, divide, compare
// and normalize on two signed 32-bit fractions.
// Input channel (s_): one beat per operation. s_tuser carries the kind code,
// s_tdata the four operands. Output channel (m_): one beat per operation
// with the reduced fraction, the compare flags and a status code in m_tuser.
// An operation runs as a sequence of microsteps on one datapath. Each gcd
// reduction takes one binary-gcd pass (one halving or subtraction per
// cycle) plus two divisions. Normalize uses one reduction, multiply and
// divide use three, add and subtract four, compare two; a bad kind or a
// zero denominator finishes with no reduction.
// One item is in flight at a time; s_tready is high only while the
// sequencer waits for a beat, and a finished result waiting in the output
// register does not block the next beat from being taken.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops
// m_tvalid. When the receiver stalls, the result holds in the output
// register and the sequencer waits before writing the next result.
`default_nettype none
module rational_arith_unit import rau_pkg::*; (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
    input  wire  [127:0] s_tdata,
    // kind [2:0]
    input  wire  [2:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // res_num [31:0], res_den [62:32], greater [63], equal [64], less [65],
    // zero fill [71:66]
    output logic [71:0]  m_tdata,
    // status [1:0]
    output logic [1:0]   m_tuser
);
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        res_gt, res_eq, res_lt;

    // Sequencer: owns the handshakes and steps the datapath.
    rau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: operand registers, gcd unit, divider, multiplier, output register.
    rau_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_data    (s_tdata),
        .in_kind    (s_tuser),
        .stat       (stat),
        .res_num    (res_num),
        .res_den    (res_den),
        .res_gt     (res_gt),
        .res_eq     (res_eq),
        .res_lt     (res_lt),
        .res_status (m_tuser)
    );

    // Pack the result beat, lowest field first.
    assign m_tdata = {6'd0, res_lt, res_eq, res_gt, res_den, res_num};
endmodule
`default_nettype wire

/* tb/sv/rational_arith_unit_tb.sv */
`default_nettype none
module rational_arith_unit_tb;
    import rau_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } op_beat_t;

    typedef struct packed {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic        greater;
        logic        equal;
        logic        less;
        logic [1:0]  status;
    } frac_res_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 1500;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
    logic [127:0]  s_tdata = '0;
    // kind [2:0]
    logic [2:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    // res_num [31:0], res_den [62:32], greater [63], equal [64], less [65]
    logic [71:0]   m_tdata;
    // status [1:0]
    logic [1:0]    m_tuser;

    op_beat_t  pending_ops[$];
    frac_res_t expected_fracs[$];
    int        mismatch_cnt = 0;
    int        idle_cycles = 0;
    bit        calm_phase = 1'b0;   // no idling in the last part of the run
    bit        hold_sink = 1'b0;    // long receiver hold-off
    int        src_gap = 0;
    int        sink_gap = 0;

    rational_arith_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #2 aclk = ~aclk;

    // Fraction as sign plus 64-bit magnitude; magnitudes of 32-bit inputs never wrap.
    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic void shrink(inout bit neg, inout logic [63:0] n, inout logic [63:0] d);
        logic [63:0] g;
        g = gcd64(n, d);
        n = n / g;
        d = d / g;
        if (n == 0) begin
            neg = 1'b0;
            d = 1;
        end
    endfunction

    function automatic void load_frac(logic [31:0] rn, logic [31:0] rd, output bit neg,
                                      output logic [63:0] n, output logic [63:0] d);
        n = rn[31] ? (64'h1_0000_0000 - {32'h0, rn}) : {32'h0, rn};
        d = rd[31] ? (64'h1_0000_0000 - {32'h0, rd}) : {32'h0, rd};
        neg = rn[31] != rd[31];
        shrink(neg, n, d);
    endfunction

    function automatic frac_res_t pack_frac(bit neg, logic [63:0] n, logic [63:0] d);
        frac_res_t r;
        r = '0;
        r.res_den = 31'd1;
        shrink(neg, n, d);
        if (d > RES_LIM || n > (neg ? RES_LIM + 1 : RES_LIM)) begin
            r.status = ST_OVF;
            return r;
        end
        r.res_num = neg ? 32'(-n) : n[31:0];
        r.res_den = d[30:0];
        r.status = ST_OK;
        return r;
    endfunction

    function automatic frac_res_t predict_frac(op_beat_t op);
        frac_res_t   r;
        bit          an, bn, sb, rneg;
        logic [63:0] a_n, a_d, b_n, b_d, g, l, ta, tb, rn;
        longint      x, y;
        r = '0;
        r.res_den = 31'd1;
        if (op.kind > K_NORM) return r;
        if (op.a_den == 0 || (op.kind != K_NORM && op.b_den == 0)) begin
            r.status = ST_ZDEN;
            return r;
        end
        load_frac(op.a_num, op.a_den, an, a_n, a_d);
        if (op.kind == K_NORM) return pack_frac(an, a_n, a_d);
        load_frac(op.b_num, op.b_den, bn, b_n, b_d);
        case (op.kind)
            K_ADD, K_SUB: begin
                g = gcd64(a_d, b_d);
                l = (a_d / g) * b_d;
                ta = a_n * (l / a_d);
                tb = b_n * (l / b_d);
                sb = (op.kind == K_SUB) ? !bn : bn;
                if (an == sb) begin
                    rn = ta + tb;
                    rneg = an;
                end else if (ta >= tb) begin
                    rn = ta - tb;
                    rneg = an;
                end else begin
                    rn = tb - ta;
                    rneg = sb;
                end
                return pack_frac(rneg, rn, l);
            end
            K_MUL: return pack_frac(an != bn, a_n * b_n, a_d * b_d);
            K_DIV: begin
                if (b_n == 0) begin
                    r.status = ST_DIVZ;
                    return r;
                end
                return pack_frac(an != bn, a_n * b_d, a_d * b_n);
            end
            default: begin
                x = an ? -longint'(a_n * b_d) : longint'(a_n * b_d);
                y = bn ? -longint'(b_n * a_d) : longint'(b_n * a_d);
                r.greater = x > y;
                r.equal = x == y;
                r.less = x < y;
                return r;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_cnt++;
    endtask

    // Driver: advance to the next pending op once the current beat is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                    src_gap <= $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    op_beat_t op;
                    op = pending_ops.pop_front();
                    expected_fracs.push_back(predict_frac(op));
                    s_tvalid <= 1'b1;
                    s_tuser <= op.kind;
                    s_tdata <= {op.b_den, op.b_num, op.a_den, op.a_num};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus the long hold-off.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_sink) begin
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        frac_res_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (expected_fracs.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[31:0], '0);
                end else begin
                    want = expected_fracs.pop_front();
                    if (m_tdata[31:0] !== want.res_num)
                        report_mismatch("res_num", m_tdata[31:0], want.res_num);
                    if (m_tdata[62:32] !== want.res_den)
                        report_mismatch("res_den", {1'b0, m_tdata[62:32]}, {1'b0, want.res_den});
                    if (m_tdata[63] !== want.greater)
                        report_mismatch("greater", {31'h0, m_tdata[63]}, {31'h0, want.greater});
                    if (m_tdata[64] !== want.equal)
                        report_mismatch("equal", {31'h0, m_tdata[64]}, {31'h0, want.equal});
                    if (m_tdata[65] !== want.less)
                        report_mismatch("less", {31'h0, m_tdata[65]}, {31'h0, want.less});
                    if (m_tuser !== want.status)
                        report_mismatch("status", {30'h0, m_tuser}, {30'h0, want.status});
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side.
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 40);
            1: return -$urandom_range(0, 40);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            4: return $urandom_range(0, 5000) * ($urandom_range(0, 1) ? 1 : -1);
            5: return 32'($urandom_range(1, 64)) << $urandom_range(0, 24);
            default: return $urandom;
        endcase
    endfunction

    function automatic op_beat_t random_op();
        op_beat_t op;
        op.kind = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
        op.a_num = pick_word();
        op.a_den = ($urandom_range(0, 40) == 0) ? 32'h0 : pick_word();
        op.b_num = ($urandom_range(0, 20) == 0) ? 32'h0 : pick_word();
        op.b_den = ($urandom_range(0, 40) == 0) ? 32'h0 : pick_word();
        if (op.a_den == 0 && $urandom_range(0, 1)) op.a_den = 1;
        if (op.b_den == 0 && $urandom_range(0, 1)) op.b_den = 1;
        return op;
    endfunction

    task automatic push_op(logic [2:0] k, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
        pending_ops.push_back('{k, an, ad, bn, bd});
    endtask

    task automatic drain_all();
        while (pending_ops.size() > 0 || expected_fracs.size() > 0 || s_tvalid)
            @(posedge aclk);
    endtask

    initial begin
        int i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every kind, sign mixes, extremes, errors, unused kinds.
        push_op(K_ADD, 1, 2, 1, 3);
        push_op(K_SUB, 1, 2, 1, 2);
        push_op(K_MUL, -3, 4, 4, -9);
        push_op(K_DIV, 2, 3, -4, 5);
        push_op(K_CMP, 1, 3, 1, 2);
        push_op(K_CMP, -2, -4, 1, 2);
        push_op(K_CMP, 3, 4, 1, 2);
        push_op(K_NORM, -6, -8, 0, 0);
        push_op(K_NORM, 0, -7, 1, 1);
        push_op(K_NORM, 32'h8000_0000, 1, 0, 0);
        push_op(K_NORM, 32'h8000_0000, -1, 0, 0);
        push_op(K_NORM, 5, 32'h8000_0000, 0, 0);
        push_op(K_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0);
        push_op(K_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
        push_op(K_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
        push_op(K_MUL, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFD);
        push_op(K_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        push_op(K_ADD, 1, 0, 1, 1);
        push_op(K_MUL, 1, 1, 1, 0);
        push_op(K_DIV, 1, 2, 0, 5);
        push_op(K_CMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001);
        push_op(3'd6, 1, 0, 1, 0);
        push_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(K_NORM, 7, 0, 0, 0);
        drain_all();

        // Long receiver hold-off while ops keep coming in.
        hold_sink <= 1'b1;
        for (i = 0; i < 6; i++) pending_ops.push_back(random_op());
        repeat (4000) @(posedge aclk);
        hold_sink <= 1'b0;
        drain_all();

        for (i = 0; i < 1300; i++) pending_ops.push_back(random_op());
        drain_all();
        calm_phase <= 1'b1;
        for (i = 0; i < 320; i++) pending_ops.push_back(random_op());
        drain_all();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0 && expected_fracs.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
